@@ sv/g3ba_pkg.sv @@
// ----------------------------------------------------------------------------
// g3ba_pkg
// Shared types, constants and control codes of the 3D box allocator.
// ----------------------------------------------------------------------------
package g3ba_pkg;

    localparam int MAX_FREE = 64;                      // free list entries
    localparam int CB       = 16;                      // coordinate bits
    localparam int AW       = $clog2(MAX_FREE);        // free list address bits
    localparam int CW       = $clog2(MAX_FREE + 1);    // counter bits, holds MAX_FREE
    localparam int FW       = 16;                      // port field width

    typedef logic [CB-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t w;
        coord_t h;
        coord_t d;
    } fbox_t;

    localparam int BOX_BITS = $bits(fbox_t);

    typedef struct packed {
        logic [FW-1:0] box_width;
        logic [FW-1:0] box_height;
        logic [FW-1:0] box_depth;
    } item_t;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        status_t       status;
        logic [FW-1:0] pos_x;
        logic [FW-1:0] pos_y;
        logic [FW-1:0] pos_z;
        logic [FW-1:0] placed_width;
        logic [FW-1:0] placed_height;
        logic [FW-1:0] placed_depth;
        logic          turned;
    } result_t;

    // register indexes
    localparam logic [2:0] REG_BIN_W  = 3'd0;
    localparam logic [2:0] REG_BIN_H  = 3'd1;
    localparam logic [2:0] REG_BIN_D  = 3'd2;
    localparam logic [2:0] REG_SPLIT  = 3'd3;
    localparam logic [2:0] REG_MERGE  = 3'd4;

    // split rules
    localparam logic [2:0] RULE_SHORT_LEFT = 3'd0;
    localparam logic [2:0] RULE_LONG_LEFT  = 3'd1;
    localparam logic [2:0] RULE_MIN_AREA   = 3'd2;
    localparam logic [2:0] RULE_MAX_AREA   = 3'd3;
    localparam logic [2:0] RULE_SHORT_AXIS = 3'd4;
    localparam logic [2:0] RULE_LONG_AXIS  = 3'd5;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_SORT_I, S_SORT_T, S_SORT_CMP, S_SORT_PUT,
        S_SCAN_I, S_SCAN_CHK,
        S_CALC, S_MUL, S_LEFT, S_OVF,
        S_RM_RD, S_RM_WR, S_APP,
        S_MG_I, S_MG_A, S_MG_J, S_MG_CMP,
        S_NOFIT, S_PLACE, S_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_INIT, OP_LOAD,
        OP_SORT_RD, OP_SORT_T, OP_SORT_SHIFT, OP_SORT_PUT, OP_SORT_END,
        OP_SCAN_RD, OP_SCAN_HIT, OP_SCAN_NEXT,
        OP_CALC, OP_MUL, OP_LEFT,
        OP_RM_START, OP_RM_RD, OP_RM_WR, OP_RM_END, OP_APP,
        OP_MG_RD, OP_MG_A, OP_MG_JRD, OP_MG_WB, OP_MG_CMP,
        OP_FAIL_FIT, OP_FAIL_FULL, OP_PLACED
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   idle;
    } cmd_t;

    typedef struct packed {
        logic box_zero;
        logic bin_wr;
        logic i_ge_cnt;
        logic j_ge_cnt;
        logic j_is1;
        logic less;
        logic fit;
        logic m1_ge_cnt;
        logic overflow;
        logic app_last;
        logic merge_en;
        logic merged;
    } stat_t;

endpackage

@@ sv/g3ba_ram.sv @@
// ----------------------------------------------------------------------------
// g3ba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module g3ba_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/g3ba_ctrl.sv @@
// ----------------------------------------------------------------------------
// g3ba_ctrl
// Sequencer: sort, scan, split, remove, append and merge passes.
// ----------------------------------------------------------------------------
module g3ba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  g3ba_pkg::stat_t stat,
    output g3ba_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);
    import g3ba_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        in_merge_reg, in_merge_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            in_merge_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_merge_reg <= in_merge_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_merge_next = in_merge_reg;
        cmd.op        = OP_NOP;
        cmd.idle      = 1'b0;
        busy          = 1'b1;
        done          = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                // a command word takes the edge, config waits
                cmd.idle = !start;
                busy     = 1'b0;
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = stat.box_zero ? S_NOFIT : S_SORT_I;
                end
                else if (stat.bin_wr)
                begin
                    state_next = S_INIT;
                end
            end
            S_SORT_I:
            begin
                if (stat.i_ge_cnt)
                begin
                    cmd.op     = OP_SORT_END;
                    state_next = S_SCAN_I;
                end
                else
                begin
                    cmd.op     = OP_SORT_RD;
                    state_next = S_SORT_T;
                end
            end
            S_SORT_T:
            begin
                cmd.op     = OP_SORT_T;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                if (stat.less)
                begin
                    cmd.op     = OP_SORT_SHIFT;
                    state_next = stat.j_is1 ? S_SORT_PUT : S_SORT_CMP;
                end
                else
                begin
                    cmd.op     = OP_SORT_PUT;
                    state_next = S_SORT_I;
                end
            end
            S_SORT_PUT:
            begin
                cmd.op     = OP_SORT_PUT;
                state_next = S_SORT_I;
            end
            S_SCAN_I:
            begin
                if (stat.i_ge_cnt)
                begin
                    state_next = S_NOFIT;
                end
                else
                begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (stat.fit)
                begin
                    cmd.op     = OP_SCAN_HIT;
                    state_next = S_CALC;
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_SCAN_I;
                end
            end
            S_CALC:
            begin
                cmd.op     = OP_CALC;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                cmd.op     = OP_LEFT;
                state_next = S_OVF;
            end
            S_OVF:
            begin
                if (stat.overflow)
                begin
                    cmd.op     = OP_FAIL_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op        = OP_RM_START;
                    in_merge_next = 1'b0;
                    state_next    = S_RM_RD;
                end
            end
            S_RM_RD:
            begin
                if (stat.m1_ge_cnt)
                begin
                    cmd.op     = OP_RM_END;
                    state_next = in_merge_reg ? S_MG_J : S_APP;
                end
                else
                begin
                    cmd.op     = OP_RM_RD;
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                cmd.op     = OP_RM_WR;
                state_next = S_RM_RD;
            end
            S_APP:
            begin
                cmd.op = OP_APP;
                if (stat.app_last)
                begin
                    state_next = stat.merge_en ? S_MG_I : S_PLACE;
                end
            end
            S_MG_I:
            begin
                if (stat.i_ge_cnt)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.op     = OP_MG_RD;
                    state_next = S_MG_A;
                end
            end
            S_MG_A:
            begin
                cmd.op     = OP_MG_A;
                state_next = S_MG_J;
            end
            S_MG_J:
            begin
                if (stat.j_ge_cnt)
                begin
                    cmd.op     = OP_MG_WB;
                    state_next = S_MG_I;
                end
                else
                begin
                    cmd.op     = OP_MG_JRD;
                    state_next = S_MG_CMP;
                end
            end
            S_MG_CMP:
            begin
                cmd.op = OP_MG_CMP;
                if (stat.merged)
                begin
                    in_merge_next = 1'b1;
                    state_next    = S_RM_RD;
                end
                else
                begin
                    state_next = S_MG_J;
                end
            end
            S_NOFIT:
            begin
                cmd.op     = OP_FAIL_FIT;
                state_next = S_DONE;
            end
            S_PLACE:
            begin
                cmd.op     = OP_PLACED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

@@ sv/g3ba_dp.sv @@
// ----------------------------------------------------------------------------
// g3ba_dp
// Datapath: free list RAM, counters, fit test, split and merge logic.
// ----------------------------------------------------------------------------
module g3ba_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  g3ba_pkg::cmd_t         cmd,
    output g3ba_pkg::stat_t        stat,
    input  g3ba_pkg::item_t        item,
    input  logic                   cfg_valid,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    output g3ba_pkg::result_t      result
);
    import g3ba_pkg::*;

    typedef struct packed {
        logic  merged;
        fbox_t box;
    } merge_t;

    // control registers
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] m_reg, m_next;
    logic [1:0]    k_reg, k_next;
    coord_t        bin_w_reg, bin_w_next;
    coord_t        bin_h_reg, bin_h_next;
    coord_t        bin_d_reg, bin_d_next;
    logic [2:0]    split_reg, split_next;
    logic          merge_reg, merge_next;

    // payload registers
    coord_t        bw_reg, bw_next, bh_reg, bh_next, bd_reg, bd_next;
    fbox_t         t_reg, t_next, a_reg, a_next, f_reg, f_next;
    logic [CW-1:0] found_reg, found_next;
    logic          turned_reg, turned_next;
    coord_t        pw_reg, pw_next, ph_reg, ph_next;
    coord_t        lw_reg, lw_next, lh_reg, lh_next, ld_reg, ld_next;
    logic [2*CB-1:0] pa_reg, pa_next, pb_reg, pb_next;
    fbox_t         l0_reg, l0_next, l1_reg, l1_next, l2_reg, l2_next;
    logic [2:0]    lv_reg, lv_next;
    result_t       res_reg, res_next;

    // RAM port
    logic          we;
    logic [AW-1:0] waddr, raddr;
    fbox_t         wdata, rdata;

    logic          fit, fit_turn, horiz;
    fbox_t         app_box;
    logic          app_v;
    merge_t        mg;
    logic          cfg_we;

    g3ba_ram #(.WIDTH(BOX_BITS), .DEPTH(MAX_FREE)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    function automatic merge_t try_merge(input fbox_t a, input fbox_t b);
        merge_t r;
        r.merged = 1'b0;
        r.box    = a;
        if (a.w == b.w && a.x == b.x && a.z == b.z && a.d == b.d)
        begin
            if (a.y == coord_t'(b.y + b.h))
            begin
                r.box.y = coord_t'(a.y - b.h); r.box.h = coord_t'(a.h + b.h); r.merged = 1'b1;
            end
            else if (coord_t'(a.y + a.h) == b.y)
            begin
                r.box.h = coord_t'(a.h + b.h); r.merged = 1'b1;
            end
        end
        else if (a.h == b.h && a.y == b.y && a.z == b.z && a.d == b.d)
        begin
            if (a.x == coord_t'(b.x + b.w))
            begin
                r.box.x = coord_t'(a.x - b.w); r.box.w = coord_t'(a.w + b.w); r.merged = 1'b1;
            end
            else if (coord_t'(a.x + a.w) == b.x)
            begin
                r.box.w = coord_t'(a.w + b.w); r.merged = 1'b1;
            end
        end
        else if (a.w == b.w && a.h == b.h && a.x == b.x && a.y == b.y)
        begin
            if (a.z == coord_t'(b.z + b.d))
            begin
                r.box.z = coord_t'(a.z - b.d); r.box.d = coord_t'(a.d + b.d); r.merged = 1'b1;
            end
            else if (coord_t'(a.z + a.d) == b.z)
            begin
                r.box.d = coord_t'(a.d + b.d); r.merged = 1'b1;
            end
        end
        return r;
    endfunction

    // fit test on the entry just read
    logic ex_up, ex_tn, ok_up, ok_tn;
    always_comb
    begin
        ex_up    = bw_reg == rdata.w && bh_reg == rdata.h && bd_reg == rdata.d;
        ex_tn    = bh_reg == rdata.w && bw_reg == rdata.h && bd_reg == rdata.d;
        ok_up    = bw_reg <= rdata.w && bh_reg <= rdata.h && bd_reg <= rdata.d;
        ok_tn    = bh_reg <= rdata.w && bw_reg <= rdata.h && bd_reg <= rdata.d;
        fit      = ex_up | ex_tn | ok_up | ok_tn;
        fit_turn = !ex_up && (ex_tn || (!ok_up && ok_tn));
    end

    always_comb
    begin
        case (split_reg)
            RULE_SHORT_LEFT: horiz = lw_reg <= lh_reg;
            RULE_LONG_LEFT:  horiz = lw_reg > lh_reg;
            RULE_MIN_AREA:   horiz = pa_reg > pb_reg;
            RULE_MAX_AREA:   horiz = pa_reg <= pb_reg;
            RULE_SHORT_AXIS: horiz = f_reg.w <= f_reg.h;
            RULE_LONG_AXIS:  horiz = f_reg.w > f_reg.h;
            default:         horiz = 1'b1;
        endcase
    end

    always_comb
    begin
        case (k_reg)
            2'd0:    begin app_box = l0_reg; app_v = lv_reg[0]; end
            2'd1:    begin app_box = l1_reg; app_v = lv_reg[1]; end
            default: begin app_box = l2_reg; app_v = lv_reg[2]; end
        endcase
    end

    assign mg     = try_merge(a_reg, rdata);
    assign cfg_we = cfg_valid && cmd.idle;

    // status to the controller
    always_comb
    begin
        stat.box_zero  = item.box_width == '0 || item.box_height == '0 || item.box_depth == '0;
        stat.bin_wr    = cfg_we && (cfg_index == REG_BIN_W || cfg_index == REG_BIN_H
                                    || cfg_index == REG_BIN_D);
        stat.i_ge_cnt  = i_reg >= count_reg;
        stat.j_ge_cnt  = j_reg >= count_reg;
        stat.j_is1     = j_reg == CW'(1);
        stat.less      = (t_reg.z != rdata.z) ? (t_reg.z < rdata.z) :
                         (t_reg.y != rdata.y) ? (t_reg.y < rdata.y) : (t_reg.x < rdata.x);
        stat.fit       = fit;
        stat.m1_ge_cnt = CW'(m_reg + CW'(1)) >= count_reg;
        stat.overflow  = ({1'b0, count_reg} + (CW+1)'($countones(lv_reg)))
                         > (CW+1)'(MAX_FREE + 1);
        stat.app_last  = k_reg == 2'd2;
        stat.merge_en  = merge_reg;
        stat.merged    = mg.merged;
    end

    always_comb
    begin
        count_next  = count_reg;  i_next = i_reg;  j_next = j_reg;
        m_next      = m_reg;      k_next = k_reg;
        bin_w_next  = bin_w_reg;  bin_h_next = bin_h_reg; bin_d_next = bin_d_reg;
        split_next  = split_reg;  merge_next = merge_reg;
        bw_next     = bw_reg;     bh_next = bh_reg;   bd_next = bd_reg;
        t_next      = t_reg;      a_next = a_reg;     f_next = f_reg;
        found_next  = found_reg;  turned_next = turned_reg;
        pw_next     = pw_reg;     ph_next = ph_reg;
        lw_next     = lw_reg;     lh_next = lh_reg;   ld_next = ld_reg;
        pa_next     = pa_reg;     pb_next = pb_reg;
        l0_next     = l0_reg;     l1_next = l1_reg;   l2_next = l2_reg;
        lv_next     = lv_reg;     res_next = res_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = rdata;
        raddr       = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_BIN_W: bin_w_next = coord_t'(cfg_data);
                REG_BIN_H: bin_h_next = coord_t'(cfg_data);
                REG_BIN_D: bin_d_next = coord_t'(cfg_data);
                REG_SPLIT: split_next = cfg_data[2:0];
                REG_MERGE: merge_next = cfg_data[0];
                default:   ;
            endcase
        end

        case (cmd.op)
            OP_INIT:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = '{x: '0, y: '0, z: '0, w: bin_w_reg, h: bin_h_reg, d: bin_d_reg};
                count_next = CW'(1);
            end
            OP_LOAD:
            begin
                bw_next = coord_t'(item.box_width);
                bh_next = coord_t'(item.box_height);
                bd_next = coord_t'(item.box_depth);
                i_next  = CW'(1);
            end
            OP_SORT_RD:
            begin
                raddr = i_reg[AW-1:0];
            end
            OP_SORT_T:
            begin
                t_next = rdata;
                j_next = i_reg;
                raddr  = AW'(i_reg - CW'(1));
            end
            OP_SORT_SHIFT:
            begin
                we     = 1'b1;
                waddr  = j_reg[AW-1:0];
                j_next = CW'(j_reg - CW'(1));
                raddr  = AW'(j_reg - CW'(2));
            end
            OP_SORT_PUT:
            begin
                we     = 1'b1;
                waddr  = j_reg[AW-1:0];
                wdata  = t_reg;
                i_next = CW'(i_reg + CW'(1));
            end
            OP_SORT_END:
            begin
                i_next = '0;
            end
            OP_SCAN_RD:
            begin
                raddr = i_reg[AW-1:0];
            end
            OP_SCAN_HIT:
            begin
                f_next      = rdata;
                found_next  = i_reg;
                turned_next = fit_turn;
            end
            OP_SCAN_NEXT:
            begin
                i_next = CW'(i_reg + CW'(1));
            end
            OP_CALC:
            begin
                pw_next = turned_reg ? bh_reg : bw_reg;
                ph_next = turned_reg ? bw_reg : bh_reg;
                lw_next = coord_t'(f_reg.w - (turned_reg ? bh_reg : bw_reg));
                lh_next = coord_t'(f_reg.h - (turned_reg ? bw_reg : bh_reg));
                ld_next = coord_t'(f_reg.d - bd_reg);
            end
            OP_MUL:
            begin
                pa_next = pw_reg * lh_reg;
                pb_next = lw_reg * ph_reg;
            end
            OP_LEFT:
            begin
                l0_next = '{x: f_reg.x, y: f_reg.y, z: coord_t'(f_reg.z + bd_reg),
                            w: pw_reg, h: ph_reg, d: ld_reg};
                l1_next = '{x: f_reg.x, y: coord_t'(f_reg.y + ph_reg), z: f_reg.z,
                            w: horiz ? f_reg.w : pw_reg, h: lh_reg, d: f_reg.d};
                l2_next = '{x: coord_t'(f_reg.x + pw_reg), y: f_reg.y, z: f_reg.z,
                            w: lw_reg, h: horiz ? ph_reg : f_reg.h, d: f_reg.d};
                lv_next[0] = pw_reg != '0 && ph_reg != '0 && ld_reg != '0;
                lv_next[1] = (horiz ? f_reg.w != '0 : pw_reg != '0)
                             && lh_reg != '0 && f_reg.d != '0;
                lv_next[2] = lw_reg != '0 && (horiz ? ph_reg != '0 : f_reg.h != '0)
                             && f_reg.d != '0;
            end
            OP_RM_START:
            begin
                m_next = found_reg;
            end
            OP_RM_RD:
            begin
                raddr = AW'(m_reg + CW'(1));
            end
            OP_RM_WR:
            begin
                we     = 1'b1;
                waddr  = m_reg[AW-1:0];
                m_next = CW'(m_reg + CW'(1));
            end
            OP_RM_END:
            begin
                count_next = CW'(count_reg - CW'(1));
                k_next     = '0;
            end
            OP_APP:
            begin
                if (app_v)
                begin
                    we         = 1'b1;
                    waddr      = count_reg[AW-1:0];
                    wdata      = app_box;
                    count_next = CW'(count_reg + CW'(1));
                end
                k_next = 2'(k_reg + 2'd1);
                i_next = '0;
            end
            OP_MG_RD:
            begin
                raddr = i_reg[AW-1:0];
            end
            OP_MG_A:
            begin
                a_next = rdata;
                j_next = CW'(i_reg + CW'(1));
            end
            OP_MG_JRD:
            begin
                raddr = j_reg[AW-1:0];
            end
            OP_MG_WB:
            begin
                we     = 1'b1;
                waddr  = i_reg[AW-1:0];
                wdata  = a_reg;
                i_next = CW'(i_reg + CW'(1));
            end
            OP_MG_CMP:
            begin
                if (mg.merged)
                begin
                    a_next = mg.box;
                    m_next = j_reg;
                end
                else
                begin
                    j_next = CW'(j_reg + CW'(1));
                end
            end
            OP_FAIL_FIT:
            begin
                res_next        = '0;
                res_next.status = ST_NO_FIT;
            end
            OP_FAIL_FULL:
            begin
                res_next        = '0;
                res_next.status = ST_FULL;
            end
            OP_PLACED:
            begin
                res_next.status        = ST_PLACED;
                res_next.pos_x         = FW'(f_reg.x);
                res_next.pos_y         = FW'(f_reg.y);
                res_next.pos_z         = FW'(f_reg.z);
                res_next.placed_width  = FW'(pw_reg);
                res_next.placed_height = FW'(ph_reg);
                res_next.placed_depth  = FW'(bd_reg);
                res_next.turned        = turned_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(1);
            i_reg     <= '0;
            j_reg     <= '0;
            m_reg     <= '0;
            k_reg     <= '0;
            bin_w_reg <= coord_t'(1024);
            bin_h_reg <= coord_t'(1024);
            bin_d_reg <= coord_t'(1024);
            split_reg <= RULE_SHORT_LEFT;
            merge_reg <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            m_reg     <= m_next;
            k_reg     <= k_next;
            bin_w_reg <= bin_w_next;
            bin_h_reg <= bin_h_next;
            bin_d_reg <= bin_d_next;
            split_reg <= split_next;
            merge_reg <= merge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bw_reg     <= bw_next;   bh_reg <= bh_next;   bd_reg <= bd_next;
        t_reg      <= t_next;    a_reg  <= a_next;    f_reg  <= f_next;
        found_reg  <= found_next;
        turned_reg <= turned_next;
        pw_reg     <= pw_next;   ph_reg <= ph_next;
        lw_reg     <= lw_next;   lh_reg <= lh_next;   ld_reg <= ld_next;
        pa_reg     <= pa_next;   pb_reg <= pb_next;
        l0_reg     <= l0_next;   l1_reg <= l1_next;   l2_reg <= l2_next;
        lv_reg     <= lv_next;
        res_reg    <= res_next;
    end

    assign result = res_reg;

endmodule

@@ sv/guillotine_3d_box_allocator_top.sv @@
// ----------------------------------------------------------------------------
// guillotine_3d_box_allocator_top
// First fit 3D box allocator over a corner-ordered guillotine free list.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and raise start; the word is taken at the
//   edge where start is high and busy is low. busy stays high until the
//   result word has been shown.
//   Result channel: done is high for exactly one cycle with the result word
//   on result; it must be taken in that cycle, there is no back pressure.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is high only while idle with start low. Writing a bin size
//   register rebuilds the free list, with busy high while it does so.
// Steps per word: a stable insertion sort of the free list, a first fit
//   scan, the split math (calc, multiply, leftovers, overflow check), the
//   removal shift, the append of each nonempty leftover and, with merging
//   on, the pairwise merge pass. All of it is paced by the one read and
//   one write port of the free list RAM.
// Reset: the list is rebuilt as one entry spanning a 1024 cube in the first
//   cycle after reset; busy is high during that cycle.
// ----------------------------------------------------------------------------
module guillotine_3d_box_allocator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  g3ba_pkg::item_t     item,
    output logic                done,
    output g3ba_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import g3ba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    g3ba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // free list, counters and arithmetic
    g3ba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    // config only lands while idle
    assign cfg_ready = cmd.idle;

endmodule

@@ sv/g3ba_checker.sv @@
// ----------------------------------------------------------------------------
// g3ba_checker
// Port level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module g3ba_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input g3ba_pkg::result_t   result,
    input logic                cfg_ready
);
    import g3ba_pkg::*;

    // a result only appears inside a command
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done outside busy");

    // done drops again after each result word
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done longer than one cycle");

    // accepted command keeps the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // config never taken mid command
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready |-> !busy)
        else $error("cfg_ready while busy");

    // rejected words carry no placement
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_PLACED) |->
        (result.pos_x == '0 && result.pos_y == '0 && result.pos_z == '0
         && result.placed_width == '0 && result.turned == 1'b0))
        else $error("reject carries placement data");

endmodule

bind guillotine_3d_box_allocator_top g3ba_checker u_g3ba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_ready (cfg_ready)
);

@@ verif/tb_guillotine_3d_box_allocator_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_guillotine_3d_box_allocator_top
// Self-checking bench: directed and random box words against a behavioral
// free list allocator, with register phases between idle points.
// ----------------------------------------------------------------------------
module tb_guillotine_3d_box_allocator_top;
    import g3ba_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 50;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    guillotine_3d_box_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Behavioral allocator state (mirrors the block's free list)
    // ------------------------------------------------------------------
    fbox_t       free_list [MAX_FREE];
    int unsigned free_cnt;
    coord_t      bin_w, bin_h, bin_d;
    logic [2:0]  rule;
    logic        merge_on;

    item_t       box_queue [$];       // words waiting for the driver
    result_t     placement_queue [$]; // expected result words
    int          error_count;
    int          stall_cycles;
    int          idle_gap;
    logic        hold_sender;         // pressure: sender waits for drain

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void rebuild_list();
        foreach (free_list[k])
            free_list[k] = '0;
        free_list[0].w = bin_w;
        free_list[0].h = bin_h;
        free_list[0].d = bin_d;
        free_cnt = 1;
    endfunction

    function automatic bit corner_lt(fbox_t a, fbox_t b);
        if (a.z != b.z) return a.z < b.z;
        if (a.y != b.y) return a.y < b.y;
        return a.x < b.x;
    endfunction

    function automatic void drop_entry(int unsigned k);
        for (int unsigned m = k; m + 1 < free_cnt; m++)
            free_list[m] = free_list[m + 1];
        if (free_cnt > 0) free_cnt--;
    endfunction

    // joins b into a when they touch on an equal face
    function automatic bit join_boxes(ref fbox_t a, input fbox_t b);
        if (a.w == b.w && a.x == b.x && a.z == b.z && a.d == b.d) begin
            if (a.y == coord_t'(b.y + b.h)) begin
                a.y = a.y - b.h; a.h = a.h + b.h; return 1;
            end else if (coord_t'(a.y + a.h) == b.y) begin
                a.h = a.h + b.h; return 1;
            end
        end else if (a.h == b.h && a.y == b.y && a.z == b.z && a.d == b.d) begin
            if (a.x == coord_t'(b.x + b.w)) begin
                a.x = a.x - b.w; a.w = a.w + b.w; return 1;
            end else if (coord_t'(a.x + a.w) == b.x) begin
                a.w = a.w + b.w; return 1;
            end
        end else if (a.w == b.w && a.h == b.h && a.x == b.x && a.y == b.y) begin
            if (a.z == coord_t'(b.z + b.d)) begin
                a.z = a.z - b.d; a.d = a.d + b.d; return 1;
            end else if (coord_t'(a.z + a.d) == b.z) begin
                a.d = a.d + b.d; return 1;
            end
        end
        return 0;
    endfunction

    function automatic result_t place_box(item_t it);
        result_t     r;
        fbox_t       t, f;
        fbox_t       parts [3];
        int unsigned found, added, j;
        bit          rot, horiz;
        coord_t      pw, ph, lw, lh, ld, bw, bh, bd;
        r = '0;
        r.status = ST_NO_FIT;
        bw = it.box_width; bh = it.box_height; bd = it.box_depth;
        if (bw == 0 || bh == 0 || bd == 0) return r;
        // stable insertion sort by (z, y, x)
        for (int unsigned i = 1; i < free_cnt; i++) begin
            t = free_list[i];
            j = i;
            while (j > 0 && corner_lt(t, free_list[j - 1])) begin
                free_list[j] = free_list[j - 1];
                j--;
            end
            free_list[j] = t;
        end
        found = MAX_FREE;
        rot = 0;
        for (int unsigned i = 0; i < free_cnt; i++) begin
            f = free_list[i];
            if (bw == f.w && bh == f.h && bd == f.d) rot = 0;
            else if (bh == f.w && bw == f.h && bd == f.d) rot = 1;
            else if (bw <= f.w && bh <= f.h && bd <= f.d) rot = 0;
            else if (bh <= f.w && bw <= f.h && bd <= f.d) rot = 1;
            else continue;
            found = i;
            break;
        end
        if (found >= MAX_FREE) return r;
        f  = free_list[found];
        pw = rot ? bh : bw;
        ph = rot ? bw : bh;
        lw = f.w - pw; lh = f.h - ph; ld = f.d - bd;
        case (rule)
            RULE_SHORT_LEFT: horiz = (lw <= lh);
            RULE_LONG_LEFT:  horiz = (lw > lh);
            RULE_MIN_AREA:   horiz = (64'(pw) * lh > 64'(lw) * ph);
            RULE_MAX_AREA:   horiz = (64'(pw) * lh <= 64'(lw) * ph);
            RULE_SHORT_AXIS: horiz = (f.w <= f.h);
            RULE_LONG_AXIS:  horiz = (f.w > f.h);
            default:         horiz = 1;
        endcase
        parts[0] = '{x: f.x, y: f.y, z: f.z + bd, w: pw, h: ph, d: ld};
        parts[1] = '{x: f.x, y: f.y + ph, z: f.z, w: horiz ? f.w : pw, h: lh, d: f.d};
        parts[2] = '{x: f.x + pw, y: f.y, z: f.z, w: lw, h: horiz ? ph : f.h, d: f.d};
        added = 0;
        foreach (parts[k])
            if (parts[k].w != 0 && parts[k].h != 0 && parts[k].d != 0) added++;
        if (free_cnt - 1 + added > MAX_FREE) begin
            r.status = ST_FULL;
            return r;
        end
        drop_entry(found);
        foreach (parts[k])
            if (parts[k].w != 0 && parts[k].h != 0 && parts[k].d != 0 && free_cnt < MAX_FREE)
            begin
                free_list[free_cnt] = parts[k];
                free_cnt++;
            end
        if (merge_on) begin
            for (int unsigned i = 0; i < free_cnt; i++) begin
                j = i + 1;
                while (j < free_cnt) begin
                    if (join_boxes(free_list[i], free_list[j])) drop_entry(j);
                    else j++;
                end
            end
        end
        r.status        = ST_PLACED;
        r.pos_x         = f.x;
        r.pos_y         = f.y;
        r.pos_z         = f.z;
        r.placed_width  = pw;
        r.placed_height = ph;
        r.placed_depth  = bd;
        r.turned        = rot;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: pulls boxes from box_queue, random gaps between words.
    // The expectation is made when the word is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start    <= 1'b0;
            item     <= '0;
            idle_gap <= 0;
        end else begin
            if (start && !busy) begin
                placement_queue.insert(placement_queue.size(), place_box(item));
            end
            if (start && busy) begin
                // keep holding the word
            end else if (idle_gap > 0) begin
                idle_gap <= idle_gap - 1;
                start    <= 1'b0;
            end else if (box_queue.size() > 0 && !hold_sender) begin
                item  <= box_queue.pop_front();
                start <= 1'b1;
                // mostly back-to-back or short gaps, a few long ones
                idle_gap <= ($urandom_range(0, 3) == 0) ?
                            (($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                         : $urandom_range(1, 4)) : 0;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done pulse is checked against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (placement_queue.size() == 0) begin
                report_mismatch("unexpected result words", 1, 0);
            end else begin
                result_t want;
                want = placement_queue.pop_front();
                if (result.status != want.status)
                    report_mismatch("status", result.status, want.status);
                if (result.pos_x != want.pos_x)
                    report_mismatch("pos_x", result.pos_x, want.pos_x);
                if (result.pos_y != want.pos_y)
                    report_mismatch("pos_y", result.pos_y, want.pos_y);
                if (result.pos_z != want.pos_z)
                    report_mismatch("pos_z", result.pos_z, want.pos_z);
                if (result.placed_width != want.placed_width)
                    report_mismatch("placed_width", result.placed_width, want.placed_width);
                if (result.placed_height != want.placed_height)
                    report_mismatch("placed_height", result.placed_height,
                                    want.placed_height);
                if (result.placed_depth != want.placed_depth)
                    report_mismatch("placed_depth", result.placed_depth, want.placed_depth);
                if (result.turned != want.turned)
                    report_mismatch("turned", result.turned, want.turned);
            end
        end
    end

    // Watchdog: cycles without an accepted word, a result or a config write
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_guillotine_3d_box_allocator_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (box_queue.size() > 0 || placement_queue.size() > 0 || start)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(val);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_BIN_W: begin bin_w = coord_t'(val); rebuild_list(); end
            REG_BIN_H: begin bin_h = coord_t'(val); rebuild_list(); end
            REG_BIN_D: begin bin_d = coord_t'(val); rebuild_list(); end
            REG_SPLIT: rule = val[2:0];
            REG_MERGE: merge_on = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_box(input int w, input int h, input int d);
        item_t it;
        it.box_width  = 16'(w);
        it.box_height = 16'(h);
        it.box_depth  = 16'(d);
        box_queue.insert(box_queue.size(), it);
    endtask

    // mostly small boxes so the list grows and merges; some bigger ones
    task automatic push_random(input int n, input int span);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       add_box($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535));
                1, 2:    add_box($urandom_range(1, span), $urandom_range(1, span),
                                 $urandom_range(1, span));
                default: add_box($urandom_range(1, span / 4 + 1),
                                 $urandom_range(1, span / 4 + 1),
                                 $urandom_range(1, span / 4 + 1));
            endcase
        end
    endtask

    initial begin
        error_count  = 0;
        stall_cycles = 0;
        hold_sender  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        bin_w = 1024; bin_h = 1024; bin_d = 1024;
        rule = RULE_SHORT_LEFT;
        merge_on = 1'b1;
        rebuild_list();
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wait (!busy);

        // directed: zero sizes, exact fits, turning, oversize, full-width bits
        add_box(0, 5, 5);
        add_box(5, 0, 5);
        add_box(5, 5, 0);
        add_box(2000, 10, 10);
        add_box(65535, 65535, 65535);
        add_box(100, 200, 300);
        add_box(200, 100, 300);
        add_box(1024, 1024, 1);
        add_box(1, 1, 1);
        add_box(924, 824, 724);
        add_box(824, 924, 700);
        add_box(512, 512, 512);
        // sender hold-off with words still pending: wait until every result is back
        while (box_queue.size() > 3) @(posedge clk);
        hold_sender = 1'b1;
        while (placement_queue.size() > 0 || start) @(posedge clk);
        hold_sender = 1'b0;
        add_box(21845, 43690, 1);
        wait_drained();

        // turned exact fit in a flat bin, then a box that no longer fits, then zero bin
        write_reg(REG_BIN_W, 40);
        write_reg(REG_BIN_H, 30);
        write_reg(REG_BIN_D, 10);
        add_box(30, 40, 10);
        add_box(1, 1, 1);
        wait_drained();
        write_reg(REG_BIN_D, 0);
        add_box(1, 1, 1);
        wait_drained();

        // walk every split rule including the unknown ones, merge on and off
        for (int r = 0; r < 8; r++) begin
            write_reg(REG_SPLIT, r);
            write_reg(REG_MERGE, r[0] ? 0 : 1);
            write_reg(REG_BIN_W, (r == 7) ? 65535 : int'($urandom_range(16, 256)));
            write_reg(REG_BIN_H, (r == 6) ? 65535 : int'($urandom_range(16, 256)));
            write_reg(REG_BIN_D, (r == 5) ? 1 : int'($urandom_range(16, 256)));
            push_random(24, 128);
            wait_drained();
        end

        // large bin with many small boxes and merging off drives the list toward full
        write_reg(REG_SPLIT, RULE_LONG_AXIS);
        write_reg(REG_MERGE, 0);
        write_reg(REG_BIN_W, 65535);
        write_reg(REG_BIN_H, 65535);
        write_reg(REG_BIN_D, 65535);
        repeat (60) add_box($urandom_range(1, 3000), $urandom_range(1, 3000),
                            $urandom_range(1, 3000));
        wait_drained();
        write_reg(REG_MERGE, 1);
        write_reg(REG_SPLIT, RULE_MIN_AREA);
        write_reg(REG_BIN_W, 1);
        write_reg(REG_BIN_H, 1);
        write_reg(REG_BIN_D, 1);
        add_box(1, 1, 1);
        add_box(1, 1, 1);
        wait_drained();
        write_reg(REG_UNUSED, 'h1234);
        write_reg(REG_BIN_W, 1024);

        wait_drained();
        if (error_count == 0)
            $display("tb_guillotine_3d_box_allocator_top: PASS");
        else
            $display("tb_guillotine_3d_box_allocator_top: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/g3ba_pkg.sv
sv/g3ba_ram.sv
sv/g3ba_ctrl.sv
sv/g3ba_dp.sv
sv/guillotine_3d_box_allocator_top.sv
sv/g3ba_checker.sv
verif/tb_guillotine_3d_box_allocator_top.sv
